FILE: rtl/core/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

    localparam int SLOTS      = 512;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 10;

    localparam logic [COUNT_BITS-1:0] FULL_LIMIT = COUNT_BITS'((SLOTS * 3) / 4);
    localparam logic [31:0]           HASH_MULT  = 32'h045d9f3b;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } lpm_cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } lpm_status_t;

    typedef struct packed {
        lpm_cmd_t              command;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } lpm_req_t;

    typedef struct packed {
        lpm_status_t           status;
        logic [VALUE_BITS-1:0] found_value;
        logic [COUNT_BITS-1:0] entry_total;
    } lpm_rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } lpm_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/lpm_ram.sv
`default_nettype none

module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lpm_hash.sv
`default_nettype none

module lpm_hash
    import lpm_pkg::*;
(
    input  logic                 clk,
    input  logic [KEY_BITS-1:0]  key,
    output logic [SLOT_BITS-1:0] home
);

    logic [31:0]          mixed;
    logic [31:0]          product;
    logic [SLOT_BITS-1:0] home_next;
    logic [SLOT_BITS-1:0] home_reg;

    // Only the low 32 bits of the product are kept, so a 32-bit multiply suffices.
    assign mixed     = key[35:4] ^ key[47:16];
    assign product   = mixed * HASH_MULT;
    assign home_next = product[SLOT_BITS-1:0];

    always_ff @(posedge clk)
    begin
        home_reg <= home_next;
    end

    assign home = home_reg;

endmodule

`default_nettype wire

FILE: rtl/core/linear_probe_pointer_map.sv
// Open-addressing map from a nonzero 64-bit key to a 32-bit value handle.
// An item is a set, get or remove command on the request port. It is taken
// at a clock edge where start is high and busy is low. Each item yields one
// result on the result port, marked by done for a single cycle; the receiver
// must take it then, since it cannot stall the block.
// Steps: an item with a zero key, a set on a full table or a no-op command
// is answered straight from the idle state; set and get hash the key, then
// probe slots from its home slot; remove then clears the found slot and scans
// the cluster after it, re-homing each entry and moving it into the hole when
// an empty slot comes before the entry itself in its probe.
// busy falls in the cycle in which done is high, so the next item may be
// taken while the result is shown. The rate is set by the single read port
// of the slot memory, which serves one probed slot per cycle.
// After reset the block sweeps the slot memory to empty, one slot a cycle,
// while busy is high; the entry count starts at zero.
`default_nettype none

module linear_probe_pointer_map
    import lpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  lpm_req_t request,
    output logic     done,
    output lpm_rsp_t result
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_LOOK,
        S_SCAN,
        S_RHOME,
        S_RLOOK,
        S_RCLR
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_BITS-1:0]  idx_reg, idx_next;
    logic [SLOT_BITS-1:0]  hole_reg, hole_next;
    lpm_cmd_t              cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    lpm_entry_t            move_reg, move_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  done_reg, done_next;
    lpm_rsp_t              rsp_reg, rsp_next;

    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    lpm_entry_t           wr_data;
    logic [SLOT_BITS-1:0] rd_addr;
    lpm_entry_t           rd_entry;
    logic [KEY_BITS-1:0]  hash_key;
    logic [SLOT_BITS-1:0] home;
    logic                 slot_empty;

    lpm_ram #(
        .WIDTH($bits(lpm_entry_t)),
        .DEPTH(SLOTS)
    ) u_slots (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_entry)
    );

    lpm_hash u_hash (
        .clk (clk),
        .key (hash_key),
        .home(home)
    );

    assign hash_key   = (state_reg == S_SCAN) ? rd_entry.key : request.key;
    assign slot_empty = (rd_entry.key == '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        hole_next  = hole_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        move_next  = move_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '0;
        rd_addr    = idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + SLOT_BITS'(1);
                if (idx_reg == SLOT_BITS'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = request.command;
                    key_next = request.key;
                    val_next = request.value;
                    rsp_next = '{ST_OK, '0, count_reg};
                    if (request.command == CMD_NOP)
                    begin
                        done_next = 1'b1;
                    end
                    else if (request.key == '0)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_ZERO;
                    end
                    else if (request.command == CMD_SET && count_reg >= FULL_LIMIT)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_HOME;
                    end
                end
            end
            S_HOME:
            begin
                rd_addr    = home;
                idx_next   = home;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (slot_empty || rd_entry.key == key_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{ST_OK, '0, count_reg};
                    case (cmd_reg)
                        CMD_SET:
                        begin
                            wr_en   = 1'b1;
                            wr_data = '{key_reg, val_reg};
                            if (slot_empty)
                            begin
                                count_next           = count_reg + COUNT_BITS'(1);
                                rsp_next.entry_total = count_next;
                            end
                        end
                        CMD_GET:
                        begin
                            if (slot_empty)
                            begin
                                rsp_next.status = ST_MISS;
                            end
                            else
                            begin
                                rsp_next.found_value = rd_entry.value;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (slot_empty)
                            begin
                                rsp_next.status = ST_MISS;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg - COUNT_BITS'(1);
                                hole_next  = idx_reg + SLOT_BITS'(1);
                                rd_addr    = idx_reg + SLOT_BITS'(1);
                                done_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + SLOT_BITS'(1);
                    rd_addr  = idx_reg + SLOT_BITS'(1);
                end
            end
            S_SCAN:
            begin
                if (slot_empty)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{ST_OK, '0, count_reg};
                end
                else
                begin
                    move_next  = rd_entry;
                    state_next = S_RHOME;
                end
            end
            S_RHOME:
            begin
                rd_addr    = home;
                idx_next   = home;
                state_next = S_RLOOK;
            end
            S_RLOOK:
            begin
                if (rd_entry.key == move_reg.key)
                begin
                    hole_next  = hole_reg + SLOT_BITS'(1);
                    rd_addr    = hole_reg + SLOT_BITS'(1);
                    state_next = S_SCAN;
                end
                else if (slot_empty)
                begin
                    wr_en      = 1'b1;
                    wr_data    = move_reg;
                    state_next = S_RCLR;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_BITS'(1);
                    rd_addr  = idx_reg + SLOT_BITS'(1);
                end
            end
            S_RCLR:
            begin
                wr_en      = 1'b1;
                wr_addr    = hole_reg;
                hole_next  = hole_reg + SLOT_BITS'(1);
                rd_addr    = hole_reg + SLOT_BITS'(1);
                state_next = S_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            hole_reg  <= '0;
            cmd_reg   <= CMD_NOP;
            key_reg   <= '0;
            val_reg   <= '0;
            move_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hole_reg  <= hole_next;
            cmd_reg   <= cmd_next;
            key_reg   <= key_next;
            val_reg   <= val_next;
            move_reg  <= move_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lpm_checker.sv
`default_nettype none

module lpm_props
    import lpm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input lpm_req_t request,
    input logic     done,
    input lpm_rsp_t result
);

    // Every result follows an accepted item or a cycle of work on one.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without an item in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_total <= FULL_LIMIT))
        else $error("entry count above the load limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> (result.entry_total == FULL_LIMIT))
        else $error("full status below the load limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.found_value == '0))
        else $error("value reported on a failed item");

endmodule

bind linear_probe_pointer_map lpm_props u_lpm_props (.*);

`default_nettype wire
